FILE: rtl/jdp_pkg.sv
// Package for the joystick dead zone and polar conversion core.
// Holds shared constants, the queue item type and the CORDIC angle table.
// No dependencies.
package jdp_pkg;

    // Number of CORDIC vectoring steps, limited by the angle table length.
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    // Divider and square root produce one bit per stage.
    localparam int QUO_BITS  = 15;
    localparam int ROOT_BITS = 15;
    localparam int BACK_N    = (CORDIC_N > ROOT_BITS) ? CORDIC_N : ROOT_BITS;

    // CORDIC datapath widths and scaling.
    localparam int PRESCALE = 8;
    localparam int CW       = 27;
    localparam int ZW       = 24;

    localparam logic signed [ZW-1:0] HALF_TURN   = 24'sd2949120;
    localparam logic signed [ZW-1:0] FULL_TURN   = 24'sd5898240;
    localparam logic [15:0]          ANGLE_STEPS = 16'd23040;
    localparam logic [14:0]          MAG_MAX     = 15'd23171;
    localparam logic [15:0]          ONE_Q14     = 16'd16384;

    // Register reset values and register indexes.
    localparam logic [14:0] DEAD_ZONE_RST  = 15'd4000;
    localparam logic [14:0] FULL_SCALE_RST = 15'd27000;
    localparam logic        REG_DEAD_ZONE  = 1'b0;
    localparam logic        REG_FULL_SCALE = 1'b1;

    // Queue between front and back.
    localparam int               Q_DEPTH = 4;
    localparam int               Q_PTR_W = 2;
    localparam logic [Q_PTR_W:0] Q_FULL  = 3'd4;

    // One normalized item handed from the front to the back.
    typedef struct packed {
        logic signed [15:0] x_norm;
        logic signed [15:0] y_norm;
        logic               stick;
    } nq_item_t;

    // atan(2^-i) in units of 2^-14 degree.
    function automatic logic signed [ZW-1:0] atan_lut(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 24'sd737280;
            1:       v = 24'sd435242;
            2:       v = 24'sd229970;
            3:       v = 24'sd116736;
            4:       v = 24'sd58595;
            5:       v = 24'sd29326;
            6:       v = 24'sd14667;
            7:       v = 24'sd7334;
            8:       v = 24'sd3667;
            9:       v = 24'sd1833;
            10:      v = 24'sd917;
            11:      v = 24'sd458;
            12:      v = 24'sd229;
            13:      v = 24'sd115;
            14:      v = 24'sd57;
            15:      v = 24'sd29;
            16:      v = 24'sd14;
            17:      v = 24'sd7;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/jdp_front.sv
// Front part: accepts raw samples, applies the dead zone and normalizes each axis.
// Normalization runs through a pipelined restoring divider, one quotient bit per stage.
// Depends on jdp_pkg.
module jdp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_x_raw,
    input  logic signed [15:0]  s_y_raw,
    input  logic                s_stick,
    input  logic [14:0]         dead_zone,
    input  logic [14:0]         full_scale,
    output logic                push_valid,
    output jdp_pkg::nq_item_t   push_item,
    input  logic                push_ready
);
    import jdp_pkg::*;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic        clamp;
        logic [14:0] rem;
        logic [14:0] low;
        logic [14:0] quo;
    } dv_lane_t;

    typedef struct packed {
        logic     stick;
        dv_lane_t x;
        dv_lane_t y;
    } fr_stage_t;

    // Dead zone test, rounding offset and clamp detection for one axis.
    function automatic dv_lane_t lane_init(input logic signed [15:0] raw,
                                           input logic [14:0] dz, input logic [14:0] fs);
        logic [15:0] mag;
        logic [29:0] num;
        logic [29:0] lim;
        dv_lane_t    l;
        mag     = raw[15] ? (~raw + 16'd1) : raw;
        num     = {mag, 14'd0} + 30'(fs[14:1]);
        lim     = {1'b0, fs, 14'd0} + 30'(fs);
        l.neg   = raw[15];
        l.zero  = (mag <= {1'b0, dz});
        l.clamp = (num >= lim);
        l.rem   = num[29:15];
        l.low   = num[14:0];
        l.quo   = 15'd0;
        return l;
    endfunction

    // One restoring division step.
    function automatic dv_lane_t lane_step(input dv_lane_t l, input logic [14:0] fs);
        logic [15:0] t;
        dv_lane_t    r;
        r = l;
        t = {l.rem, l.low[14]};
        if (t >= {1'b0, fs}) begin
            r.rem = 15'(t - {1'b0, fs});
            r.quo = {l.quo[13:0], 1'b1};
        end else begin
            r.rem = t[14:0];
            r.quo = {l.quo[13:0], 1'b0};
        end
        r.low = {l.low[13:0], 1'b0};
        return r;
    endfunction

    // Final normalized value with sign.
    function automatic logic signed [15:0] lane_out(input dv_lane_t l);
        logic [15:0] q;
        if (l.zero) begin
            q = 16'd0;
        end else if (l.clamp) begin
            q = ONE_Q14;
        end else begin
            q = {1'b0, l.quo};
        end
        return l.neg ? $signed(~q + 16'd1) : $signed(q);
    endfunction

    fr_stage_t           st_reg [0:QUO_BITS];
    logic [QUO_BITS:0]   vld_reg;
    logic                en;

    // The pipeline advances unless its last item is blocked by a full queue.
    assign en      = !vld_reg[QUO_BITS] || push_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUO_BITS-1:0], s_valid};
        end
    end

    // Divider stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].stick <= s_stick;
            st_reg[0].x     <= lane_init(s_x_raw, dead_zone, full_scale);
            st_reg[0].y     <= lane_init(s_y_raw, dead_zone, full_scale);
            for (int j = 0; j < QUO_BITS; j++) begin
                st_reg[j+1].stick <= st_reg[j].stick;
                st_reg[j+1].x     <= lane_step(st_reg[j].x, full_scale);
                st_reg[j+1].y     <= lane_step(st_reg[j].y, full_scale);
            end
        end
    end

    assign push_valid       = vld_reg[QUO_BITS];
    assign push_item.x_norm = lane_out(st_reg[QUO_BITS].x);
    assign push_item.y_norm = lane_out(st_reg[QUO_BITS].y);
    assign push_item.stick  = st_reg[QUO_BITS].stick;

endmodule

FILE: rtl/jdp_queue.sv
// Short queue that decouples the normalizing front from the polar back.
// Holds nq_item_t entries in a small register file.
// Depends on jdp_pkg.
module jdp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  jdp_pkg::nq_item_t push_item,
    output logic              push_ready,
    output logic              pop_valid,
    output jdp_pkg::nq_item_t pop_item,
    input  logic              pop_ready
);
    import jdp_pkg::*;

    nq_item_t           mem_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   cnt_reg;
    logic               push;
    logic               pop;

    assign push_ready = (cnt_reg != Q_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/jdp_back.sv
// Back part: squares and sums the normalized axes, then runs a pipelined square root
// and a CORDIC vectoring pipeline side by side, and registers the result item.
// Depends on jdp_pkg.
module jdp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    input  jdp_pkg::nq_item_t  pop_item,
    output logic               pop_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_x_norm,
    output logic signed [15:0] m_y_norm,
    output logic [14:0]        m_magnitude,
    output logic [14:0]        m_angle,
    output logic               m_stick_out
);
    import jdp_pkg::*;

    typedef struct packed {
        logic signed [15:0]   xn;
        logic signed [15:0]   yn;
        logic                 stick;
        logic                 zero;
        logic [30:0]          rem;
        logic [14:0]          root;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] cz;
    } bk_stage_t;

    // Squares, sum and CORDIC pre-rotation into the right half plane.
    function automatic bk_stage_t pre_init(input nq_item_t it);
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        bk_stage_t            s;
        px      = it.x_norm * it.x_norm;
        py      = it.y_norm * it.y_norm;
        ex      = CW'(it.x_norm) <<< PRESCALE;
        ey      = CW'(it.y_norm) <<< PRESCALE;
        s.xn    = it.x_norm;
        s.yn    = it.y_norm;
        s.stick = it.stick;
        s.zero  = (it.x_norm == 16'sd0) && (it.y_norm == 16'sd0);
        s.rem   = 31'(px) + 31'(py);
        s.root  = '0;
        if (it.x_norm < 16'sd0) begin
            s.cx = -ex;
            s.cy = -ey;
            s.cz = HALF_TURN;
        end else begin
            s.cx = ex;
            s.cy = ey;
            s.cz = '0;
        end
        return s;
    endfunction

    // One square root digit and one CORDIC rotation, each where its count allows.
    function automatic bk_stage_t iter_step(input bk_stage_t s, input int j);
        logic [30:0]          trial;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        bk_stage_t            r;
        int                   k;
        r = s;
        if (j < ROOT_BITS) begin
            k     = ROOT_BITS - 1 - j;
            trial = (31'(s.root) << (k + 1)) + (31'd1 << (2 * k));
            if (s.rem >= trial) begin
                r.rem  = s.rem - trial;
                r.root = s.root | (15'd1 << k);
            end
        end
        if (j < CORDIC_N) begin
            xs = s.cx >>> j;
            ys = s.cy >>> j;
            if (!s.cy[CW-1]) begin
                r.cx = s.cx + ys;
                r.cy = s.cy - xs;
                r.cz = s.cz + atan_lut(j);
            end else begin
                r.cx = s.cx - ys;
                r.cy = s.cy + xs;
                r.cz = s.cz - atan_lut(j);
            end
        end
        return r;
    endfunction

    bk_stage_t           pre_reg;
    bk_stage_t           it_reg [0:BACK_N-1];
    logic [BACK_N:0]     vld_reg;
    logic                m_valid_reg;
    logic                en;
    bk_stage_t           last;
    logic signed [ZW-1:0] total;
    logic [ZW-1:0]       tsum;
    logic [15:0]         steps;
    logic [14:0]         mag_round;
    logic [14:0]         ang_round;

    // The whole back pipeline moves unless the output holds an untaken item.
    assign en        = !m_valid_reg || m_ready;
    assign pop_ready = en;
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[BACK_N-1:0], pop_valid};
            m_valid_reg <= vld_reg[BACK_N];
        end
    end

    // Rounding of the root and folding of the angle into one turn.
    always_comb begin
        last      = it_reg[BACK_N-1];
        mag_round = (last.rem > 31'(last.root)) ? (last.root + 15'd1) : last.root;
        total     = (last.cz < 0) ? (last.cz + FULL_TURN) : last.cz;
        tsum      = total + 24'd128;
        steps     = tsum[ZW-1:8];
        if (last.zero || (steps == ANGLE_STEPS)) begin
            ang_round = '0;
        end else begin
            ang_round = steps[14:0];
        end
    end

    // Datapath stages and output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg   <= pre_init(pop_item);
            it_reg[0] <= iter_step(pre_reg, 0);
            for (int j = 1; j < BACK_N; j++) begin
                it_reg[j] <= iter_step(it_reg[j-1], j);
            end
            m_x_norm    <= last.xn;
            m_y_norm    <= last.yn;
            m_stick_out <= last.stick;
            m_magnitude <= mag_round;
            m_angle     <= ang_round;
        end
    end

    // Result ranges and the zero vector case.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({1'b0, m_angle} < ANGLE_STEPS))
        else $error("angle out of range");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_magnitude <= MAG_MAX))
        else $error("magnitude out of range");

    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_x_norm == 16'sd0 && m_y_norm == 16'sd0)
        |-> (m_angle == '0 && m_magnitude == '0))
        else $error("zero vector gives nonzero result");

endmodule

FILE: rtl/joystick_deadzone_polar_core.sv
// Each divider, root and CORDIC stage is a register stage.
// Throughput: one item per cycle unless the result side stalls the pipeline.
// The four-entry queue lets the front keep accepting while the result side stalls.
// Reset (aresetn, synchronous, active low) empties all stages and the queue and sets
// dead_zone to 4000 and full_scale to 27000.
module joystick_deadzone_polar_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_x_raw,
    input  logic signed [15:0] s_y_raw,
    input  logic               s_stick,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_x_norm,
    output logic signed [15:0] m_y_norm,
    output logic [14:0]        m_magnitude,
    output logic [14:0]        m_angle,
    output logic               m_stick_out,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data
);
    import jdp_pkg::*;

    logic [14:0] dead_zone_reg;
    logic [14:0] full_scale_reg;
    logic        push_valid;
    logic        push_ready;
    nq_item_t    push_item;
    logic        pop_valid;
    logic        pop_ready;
    nq_item_t    pop_item;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg  <= DEAD_ZONE_RST;
            full_scale_reg <= FULL_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEAD_ZONE:  dead_zone_reg  <= cfg_data;
                REG_FULL_SCALE: full_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    jdp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_x_raw    (s_x_raw),
        .s_y_raw    (s_y_raw),
        .s_stick    (s_stick),
        .dead_zone  (dead_zone_reg),
        .full_scale (full_scale_reg),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    jdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    jdp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_item    (pop_item),
        .pop_ready   (pop_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_norm    (m_x_norm),
        .m_y_norm    (m_y_norm),
        .m_magnitude (m_magnitude),
        .m_angle     (m_angle),
        .m_stick_out (m_stick_out)
    );

endmodule

FILE: tb/sv/tb_joystick_deadzone_polar_core.sv
// Testbench for joystick_deadzone_polar_core: dead zone, normalization and polar conversion.
// Depends on jdp_pkg and the core; predicts every result and compares it field by field.
`timescale 1ns / 100ps

module tb_joystick_deadzone_polar_core;
    import jdp_pkg::*;

    typedef struct {
        logic signed [15:0] x_raw;
        logic signed [15:0] y_raw;
        logic               stick;
    } sample_t;

    typedef struct {
        logic signed [15:0] x_norm;
        logic signed [15:0] y_norm;
        logic [14:0]        magnitude;
        logic [14:0]        angle;
        logic               stick_out;
    } polar_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_x_raw;
    logic signed [15:0] s_y_raw;
    logic               s_stick;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_x_norm;
    logic signed [15:0] m_y_norm;
    logic [14:0]        m_magnitude;
    logic [14:0]        m_angle;
    logic               m_stick_out;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [14:0]        cfg_data;

    sample_t sample_queue[$];
    polar_t  expected_polar[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    bit      stim_done = 0;
    bit      in_acc = 1'b0;
    bit      out_acc = 1'b0;
    logic [14:0] dead_zone_q;
    logic [14:0] full_scale_q;

    joystick_deadzone_polar_core DUT (.*);

    // Clock with a 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Cycle counter ends a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Handshakes seen at the rising edge, held for the falling-edge drivers.
    always @(posedge aclk) begin
        in_acc  <= aresetn && s_valid && s_ready;
        out_acc <= aresetn && m_valid && m_ready;
    end

    // Scale one raw axis to Q2.14 with dead zone and clamping.
    function automatic logic signed [15:0] norm_axis(logic signed [15:0] raw);
        longint mag;
        longint q;
        mag = (raw < 0) ? -longint'(raw) : longint'(raw);
        if (mag <= dead_zone_q) return 16'sd0;
        if (full_scale_q == 0) q = 16384;
        else begin
            q = (mag * 16384 + full_scale_q / 2) / full_scale_q;
            if (q > 16384) q = 16384;
        end
        return (raw < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic longint floor_sh(longint v, int s);
        return (v >= 0) ? (v >>> s) : (-(((-v) - 1) >>> s) - 1);
    endfunction

    function automatic logic [14:0] vector_length(longint sq);
        longint r;
        longint t;
        r = 0;
        for (int b = 30; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= sq) r = t;
        end
        if (r * r + r < sq) r++;
        return 15'(r);
    endfunction

    // Vectoring CORDIC on a 2^-14 degree accumulator, rounded to 1/64 degree.
    function automatic logic [14:0] vector_angle(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        longint steps;
        z = 0;
        if (x == 0 && y == 0) return 15'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * 16384;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_lut(i));
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_lut(i));
            end
        end
        while (z < 0) z += 360 * 16384;
        while (z >= 360 * 16384) z -= 360 * 16384;
        steps = (z + 128) >>> 8;
        if (steps >= 23040) steps -= 23040;
        return 15'(steps);
    endfunction

    function automatic polar_t predict_polar(sample_t s);
        polar_t p;
        longint xn;
        longint yn;
        p.x_norm = norm_axis(s.x_raw);
        p.y_norm = norm_axis(s.y_raw);
        xn = p.x_norm;
        yn = p.y_norm;
        p.magnitude = vector_length(xn * xn + yn * yn);
        p.angle = vector_angle(xn, yn);
        p.stick_out = s.stick;
        return p;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Driver: presents queued items with random gaps between them.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (in_acc) begin
            send_gap = $urandom_range(0, 4);
            if (send_gap == 0 && sample_queue.size() > 0) begin
                s_x_raw <= sample_queue[0].x_raw;
                s_y_raw <= sample_queue[0].y_raw;
                s_stick <= sample_queue[0].stick;
                sample_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (sample_queue.size() > 0) begin
                s_valid <= 1'b1;
                s_x_raw <= sample_queue[0].x_raw;
                s_y_raw <= sample_queue[0].y_raw;
                s_stick <= sample_queue[0].stick;
                sample_queue.pop_front();
            end
        end
    end

    // The prediction is made when an item is accepted.
    always @(posedge aclk) begin
        sample_t s;
        if (aresetn && s_valid && s_ready) begin
            s.x_raw = s_x_raw;
            s.y_raw = s_y_raw;
            s.stick = s_stick;
            expected_polar.insert(expected_polar.size(), predict_polar(s));
        end
    end

    // Result side stalls at random.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (out_acc) begin
            recv_gap = $urandom_range(0, 4);
            if (recv_gap != 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (recv_gap > 0) recv_gap--;
            else m_ready <= 1'b1;
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge aclk) begin
        polar_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_polar.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                e = expected_polar.pop_front();
                if (m_x_norm !== e.x_norm) report_mismatch("x_norm", m_x_norm, e.x_norm);
                if (m_y_norm !== e.y_norm) report_mismatch("y_norm", m_y_norm, e.y_norm);
                if (m_magnitude !== e.magnitude)
                    report_mismatch("magnitude", m_magnitude, e.magnitude);
                if (m_angle !== e.angle) report_mismatch("angle", m_angle, e.angle);
                if (m_stick_out !== e.stick_out)
                    report_mismatch("stick_out", m_stick_out, e.stick_out);
            end
        end
    end

    task automatic add_sample(logic signed [15:0] x, logic signed [15:0] y, logic st);
        sample_t s;
        s.x_raw = x;
        s.y_raw = y;
        s.stick = st;
        sample_queue.insert(sample_queue.size(), s);
    endtask

    // Wait until every queued item is accepted and every result has come.
    task automatic drain();
        while (sample_queue.size() > 0 || s_valid || expected_polar.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DEAD_ZONE) dead_zone_q = val;
        else full_scale_q = val;
    endtask

    // Random samples: each axis lies near the dead zone, near full scale, within +-20000 or fully random.
    task automatic add_random(int count);
        logic signed [15:0] v[2];
        for (int n = 0; n < count; n++) begin
            for (int a = 0; a < 2; a++) begin
                case ($urandom_range(0, 3))
                    0: v[a] = 16'($urandom);
                    1: v[a] = 16'(int'(dead_zone_q) + $urandom_range(0, 4) - 2);
                    2: v[a] = 16'(int'(full_scale_q) + $urandom_range(0, 64) - 32);
                    default: v[a] = 16'($urandom_range(0, 40000) - 20000);
                endcase
                if ($urandom_range(0, 1)) v[a] = -v[a];
            end
            add_sample(v[0], v[1], 1'($urandom));
        end
    endtask

    // Stimulus: directed corners, then random phases over several settings.
    initial begin
        s_valid   = 1'b0;
        m_ready   = 1'b0;
        s_x_raw   = '0;
        s_y_raw   = '0;
        s_stick   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DEAD_ZONE;
        cfg_data  = '0;
        dead_zone_q  = DEAD_ZONE_RST;
        full_scale_q = FULL_SCALE_RST;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_sample(16'sd0, 16'sd0, 1'b0);
        add_sample(16'sd4000, 16'sd4001, 1'b1);
        add_sample(-16'sd4000, -16'sd4001, 1'b0);
        add_sample(16'sd32767, 16'sd0, 1'b1);
        add_sample(-16'sd32768, 16'sd0, 1'b0);
        add_sample(16'sd0, -16'sd32768, 1'b1);
        add_sample(16'sd0, 16'sd32767, 1'b0);
        add_sample(-16'sd32768, -16'sd32768, 1'b1);
        add_sample(16'sd27000, 16'sd27000, 1'b0);
        add_sample(-16'sd27000, 16'sd27000, 1'b1);
        add_sample(16'sd20000, -16'sd1, 1'b0);
        add_sample(16'sd20000, -16'sd5000, 1'b1);
        add_sample(-16'sd20000, -16'sd5000, 1'b0);
        add_sample(-16'sd20000, 16'sd5000, 1'b1);
        add_sample(-16'sd5000, 16'sd0, 1'b0);
        add_random(100);
        drain();

        // Full scale zero saturates; smallest dead zone.
        write_reg(REG_FULL_SCALE, 15'd0);
        write_reg(REG_DEAD_ZONE, 15'd0);
        add_sample(16'sd1, -16'sd1, 1'b0);
        add_sample(16'sd0, -16'sd32768, 1'b1);
        add_random(60);
        drain();

        write_reg(REG_FULL_SCALE, 15'd1);
        add_random(60);
        drain();

        // Largest dead zone: only the most negative sample passes.
        write_reg(REG_DEAD_ZONE, 15'd32767);
        write_reg(REG_FULL_SCALE, 15'd32767);
        add_sample(-16'sd32768, 16'sd32767, 1'b1);
        add_sample(16'sd32767, -16'sd32768, 1'b0);
        add_random(40);
        drain();

        write_reg(REG_DEAD_ZONE, 15'($urandom_range(0, 3000)));
        write_reg(REG_FULL_SCALE, 15'($urandom_range(1000, 32767)));
        add_random(90);
        drain();

        write_reg(REG_DEAD_ZONE, 15'd100);
        write_reg(REG_FULL_SCALE, 15'd300);
        add_random(90);
        drain();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/jdp_pkg.sv
rtl/jdp_front.sv
rtl/jdp_queue.sv
rtl/jdp_back.sv
rtl/joystick_deadzone_polar_core.sv
tb/sv/tb_joystick_deadzone_polar_core.sv
